// ===== rtl/codebook_lut_accumulate_assert.svh =====
// assertion macros for the codebook lookup-table accumulator
// used by rtl/codebook_lut_accumulate.sv, no other dependencies
`ifndef CODEBOOK_LUT_ACCUMULATE_ASSERT_SVH
`define CODEBOOK_LUT_ACCUMULATE_ASSERT_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define CLA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CLA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CLA_ASSERT(label, clk, rst_n, prop, msg)

`define CLA_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/cla_pkg.sv =====
// shared types, sizes and helpers for the codebook lookup-table accumulator
// no dependencies; imported by cla_table and codebook_lut_accumulate
package cla_pkg;

    localparam int BOOK_COUNT    = 4;
    localparam int BOOK_ENTRIES  = 256;
    localparam int FEATURE_COUNT = 8192;
    localparam int CODE_FIELDS   = 4;

    localparam int NUM_LANES = (BOOK_COUNT < CODE_FIELDS) ? BOOK_COUNT : CODE_FIELDS;
    localparam int ENTRY_AW  = (BOOK_ENTRIES > 1) ? $clog2(BOOK_ENTRIES) : 1;
    localparam int FEAT_AW   = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

    localparam int OP_W     = 2;
    localparam int BOOK_W   = 2;
    localparam int CODE_W   = 8;
    localparam int FEAT_W   = 13;
    localparam int DATA_W   = 32;
    localparam int ACC_W    = 32;
    localparam int CFG_W    = 3;
    localparam int ENTRY_W  = 16;
    localparam int TOTAL_W  = ENTRY_W + ((NUM_LANES > 1) ? $clog2(NUM_LANES) : 0);

    localparam logic [CFG_W-1:0] BOOKS_RESET = CFG_W'(4);

    typedef enum logic [OP_W-1:0] {
        OP_TABLE_WR = 2'd0,
        OP_PRESET   = 2'd1,
        OP_ACCUM    = 2'd2,
        OP_READ     = 2'd3
    } t_op;

    typedef struct packed {
        t_op                       operation;
        logic [BOOK_W-1:0]         codebook_select;
        logic [CODE_W-1:0]         entry_index;
        logic [FEAT_W-1:0]         feature_index;
        logic signed [DATA_W-1:0]  data_value;
        logic [CODE_W-1:0]         code_0;
        logic [CODE_W-1:0]         code_1;
        logic [CODE_W-1:0]         code_2;
        logic [CODE_W-1:0]         code_3;
    } t_in_req;

    typedef struct packed {
        logic signed [ACC_W-1:0]   sum_value;
        logic [FEAT_W-1:0]         sum_feature;
        logic                      saturated;
    } t_out_rsp;

    typedef struct packed {
        logic                      en;
        logic [BOOK_W-1:0]         book;
        logic [CODE_W-1:0]         entry;
        logic signed [ENTRY_W-1:0] value;
    } t_tbl_wr;

    typedef struct packed {
        logic                      mark;
        logic signed [ACC_W-1:0]   value;
    } t_acc_word;

    typedef logic [CODE_FIELDS-1:0][CODE_W-1:0] t_codes;

    function automatic logic signed [ENTRY_W-1:0] sat_entry(input logic signed [DATA_W-1:0] v);
        logic signed [ENTRY_W-1:0] r;
        if (v > DATA_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -DATA_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = ENTRY_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== rtl/cla_table.sv =====
// banked partial-product table: one synchronous memory per codebook lane
// registers the selected entries, then their sum; depends on cla_pkg
module cla_table import cla_pkg::*; (
    input  logic                       i_clk,
    input  t_tbl_wr                    i_wr,
    input  logic                       i_rd_en,
    input  t_codes                     i_codes,
    input  logic [NUM_LANES-1:0]       i_lane_use,
    output logic signed [TOTAL_W-1:0]  o_total
);

    logic signed [ENTRY_W-1:0] r_rd [NUM_LANES];
    logic [NUM_LANES-1:0]      r_use;
    logic signed [TOTAL_W-1:0] r_total;
    logic signed [TOTAL_W-1:0] n_total;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_bank
        logic signed [ENTRY_W-1:0] r_bank [BOOK_ENTRIES];

        always_ff @(posedge i_clk) begin
            if (i_wr.en && (i_wr.book == BOOK_W'(g)) &&
                (32'(i_wr.entry) < BOOK_ENTRIES)) begin
                r_bank[ENTRY_AW'(i_wr.entry)] <= i_wr.value;
            end
            if (i_rd_en) begin
                r_rd[g]  <= r_bank[ENTRY_AW'(i_codes[g])];
                r_use[g] <= i_lane_use[g] && (32'(i_codes[g]) < BOOK_ENTRIES);
            end
        end
    end

    always_comb begin
        n_total = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (r_use[l]) begin
                n_total = n_total + TOTAL_W'(r_rd[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
    end

    assign o_total = r_total;

endmodule

// ===== rtl/codebook_lut_accumulate.sv =====
// top level of the codebook lookup-table accumulator
// accumulator memory and request sequencer; depends on cla_pkg, cla_table
//
//  channel   direction  handshake                payload
//  in        input      i_in_valid / o_in_stall  i_in_req  (t_in_req)
//  out       output     o_out_valid / i_out_stall o_out_rsp (t_out_rsp)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (codebooks in use)
//
// table write and preset complete when accepted; a read passes through the read state,
// an accumulate through read and write (accept with memory reads, table sum, accumulator add and write back)
// one request in flight; the accumulator memory has one read and one write port
// a read waits in the read state while the output register is still held
// reset clears the sequencer and output valid and sets the codebook count to 4
// memories are not cleared: table and accumulators are defined once written
module codebook_lut_accumulate import cla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_req           i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_rsp          o_out_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    `include "codebook_lut_accumulate_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE
    } t_state;

    t_state                    r_state;
    t_op                       r_op;
    logic [FEAT_W-1:0]         r_feat;
    logic                      r_out_valid;
    t_out_rsp                  r_out;
    logic [CFG_W-1:0]          r_books;
    t_acc_word                 r_acc_rd;
    t_acc_word                 r_acc_mem [FEATURE_COUNT];

    logic                      in_accept;
    logic                      feat_ok;
    logic [NUM_LANES-1:0]      lane_use;
    logic                      acc_rd_en;
    logic                      tbl_rd_en;
    t_tbl_wr                   tbl_wr;
    t_codes                    codes;
    logic signed [TOTAL_W-1:0] total;
    logic signed [ACC_W:0]     sum_wide;
    logic                      clip;
    t_acc_word                 n_acc_wdata;
    logic [FEAT_W-1:0]         n_acc_waddr;
    logic                      n_acc_we;
    logic                      out_free;
    logic                      out_load;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_load    = (r_state == S_READ) && (r_op != OP_ACCUM) && out_free;

    assign feat_ok = 32'(i_in_req.feature_index) < FEATURE_COUNT;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            lane_use[l] = 32'(r_books) > l;
        end
    end

    assign codes = {i_in_req.code_3, i_in_req.code_2, i_in_req.code_1, i_in_req.code_0};

    assign tbl_rd_en = in_accept && (i_in_req.operation == OP_ACCUM) && feat_ok
                       && (lane_use != '0);
    assign acc_rd_en = tbl_rd_en ||
                       (in_accept && (i_in_req.operation == OP_READ) && feat_ok);

    always_comb begin
        tbl_wr.en    = in_accept && (i_in_req.operation == OP_TABLE_WR);
        tbl_wr.book  = i_in_req.codebook_select;
        tbl_wr.entry = i_in_req.entry_index;
        tbl_wr.value = sat_entry(i_in_req.data_value);
    end

    cla_table u_table (
        .i_clk      (i_clk),
        .i_wr       (tbl_wr),
        .i_rd_en    (tbl_rd_en),
        .i_codes    (codes),
        .i_lane_use (lane_use),
        .o_total    (total)
    );

    // accumulate and saturate to the signed 32-bit range
    assign sum_wide = (ACC_W+1)'(r_acc_rd.value) + (ACC_W+1)'(total);
    assign clip     = sum_wide[ACC_W] != sum_wide[ACC_W-1];

    always_comb begin
        n_acc_we    = 1'b0;
        n_acc_waddr = i_in_req.feature_index;
        n_acc_wdata.mark  = 1'b0;
        n_acc_wdata.value = i_in_req.data_value;
        if (r_state == S_WRITE) begin
            n_acc_we    = 1'b1;
            n_acc_waddr = r_feat;
            n_acc_wdata.mark = r_acc_rd.mark || clip;
            if (!clip) begin
                n_acc_wdata.value = sum_wide[ACC_W-1:0];
            end else if (sum_wide[ACC_W]) begin
                n_acc_wdata.value = {1'b1, {(ACC_W-1){1'b0}}};
            end else begin
                n_acc_wdata.value = {1'b0, {(ACC_W-1){1'b1}}};
            end
        end else if (in_accept && (i_in_req.operation == OP_PRESET) && feat_ok) begin
            n_acc_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_acc_we) begin
            r_acc_mem[FEAT_AW'(n_acc_waddr)] <= n_acc_wdata;
        end
        if (acc_rd_en) begin
            r_acc_rd <= r_acc_mem[FEAT_AW'(i_in_req.feature_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_books <= BOOKS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_books <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_op        <= OP_TABLE_WR;
        end else begin
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc_rd_en) begin
                        r_state <= S_READ;
                        r_op    <= i_in_req.operation;
                        r_feat  <= i_in_req.feature_index;
                    end
                end
                S_READ: begin
                    if (r_op == OP_ACCUM) begin
                        r_state <= S_WRITE;
                    end else if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.sum_value   <= r_acc_rd.value;
                        r_out.sum_feature <= r_feat;
                        r_out.saturated   <= r_acc_rd.mark;
                        r_state           <= S_IDLE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `CLA_ASSERT(a_write_after_read, i_clk, i_rst_n, (r_state == S_WRITE) |-> ($past(r_state) == S_READ && r_op == OP_ACCUM), "write back without a preceding read")
    `CLA_ASSERT(a_no_accept_in_write, i_clk, i_rst_n, (r_state == S_WRITE) |-> !in_accept, "request accepted during write back")
    `CLA_ASSERT(a_out_from_read, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_READ && $past(r_op) == OP_READ), "result not caused by a read")
    `CLA_ASSERT(a_read_request, i_clk, i_rst_n, (in_accept && i_in_req.operation == OP_READ && feat_ok) |=> (r_state == S_READ && r_op == OP_READ), "read request not sequenced")
    `CLA_ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> (!o_out_valid && r_state == S_IDLE), "reset did not clear the sequencer")

endmodule

// ===== test/tb_codebook_lut_accumulate.sv =====
`timescale 1ns / 100ps
// self-checking testbench for codebook_lut_accumulate: table writes, presets, accumulates
// and reads checked against a scoreboard model under random idling; depends on cla_pkg
module tb_codebook_lut_accumulate;
    import cla_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int SEGMENT_ITEMS = 290;
    localparam longint ACC_MAX   = 64'sd2147483647;
    localparam longint ACC_MIN   = -64'sd2147483648;

    class lut_accum_scoreboard;
        logic signed [ENTRY_W-1:0] lut [BOOK_COUNT][BOOK_ENTRIES];
        logic signed [ACC_W-1:0]   acc [FEATURE_COUNT];
        bit                        clipped [FEATURE_COUNT];
        logic [CFG_W-1:0]          books;
        t_out_rsp                  readouts_due [$];
        int unsigned               mismatches;
        int unsigned               readouts_checked;
        int unsigned               clipped_seen;

        function new();
            books = BOOKS_RESET;
            mismatches = 0;
            readouts_checked = 0;
            clipped_seen = 0;
        endfunction

        function void note_request(t_in_req r);
            logic [CODE_W-1:0] codes [CODE_FIELDS];
            int unsigned       lanes;
            longint            total;
            longint            sum;
            int                f;
            t_out_rsp          want;
            f = int'(r.feature_index);
            codes = '{r.code_0, r.code_1, r.code_2, r.code_3};
            case (r.operation)
                OP_TABLE_WR: begin
                    if (r.data_value > 32767) begin
                        lut[r.codebook_select][r.entry_index] = 16'sh7fff;
                    end else if (r.data_value < -32768) begin
                        lut[r.codebook_select][r.entry_index] = 16'sh8000;
                    end else begin
                        lut[r.codebook_select][r.entry_index] = r.data_value[ENTRY_W-1:0];
                    end
                end
                OP_PRESET: begin
                    acc[f] = r.data_value;
                    clipped[f] = 1'b0;
                end
                OP_ACCUM: begin
                    lanes = (books > NUM_LANES) ? NUM_LANES : books;
                    if (lanes != 0) begin
                        total = 0;
                        for (int c = 0; c < lanes; c++) begin
                            total += lut[c][codes[c]];
                        end
                        sum = longint'(acc[f]) + total;
                        if (sum > ACC_MAX) begin
                            sum = ACC_MAX;
                            clipped[f] = 1'b1;
                        end else if (sum < ACC_MIN) begin
                            sum = ACC_MIN;
                            clipped[f] = 1'b1;
                        end
                        acc[f] = sum[ACC_W-1:0];
                    end
                end
                OP_READ: begin
                    want.sum_value   = acc[f];
                    want.sum_feature = r.feature_index;
                    want.saturated   = clipped[f];
                    readouts_due.push_back(want);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_readout(t_out_rsp got);
            t_out_rsp want;
            if (readouts_due.size() == 0) begin
                $error("readout with none pending: feature %0d value %0d",
                       got.sum_feature, got.sum_value);
                mismatches++;
                return;
            end
            want = readouts_due.pop_front();
            readouts_checked++;
            if (got.saturated === 1'b1) clipped_seen++;
            if (got.sum_value !== want.sum_value) begin
                $error("sum_value expected %0d got %0d", want.sum_value, got.sum_value);
                mismatches++;
            end
            if (got.sum_feature !== want.sum_feature) begin
                $error("sum_feature expected %0d got %0d", want.sum_feature, got.sum_feature);
                mismatches++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated expected %0d got %0d", want.saturated, got.saturated);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_req          i_in_req    = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_rsp         o_out_rsp;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    lut_accum_scoreboard scoreboard = new();

    int unsigned cycle_count   = 0;
    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;
    int unsigned op_count [4]  = '{0, 0, 0, 0};

    // generator bookkeeping: only written entries and preset features are ever read
    bit lut_live [BOOK_COUNT][BOOK_ENTRIES];
    int live_codes [BOOK_COUNT][$];
    bit feat_live [FEATURE_COUNT];
    int live_feats [$];
    int last_feat = 0;

    codebook_lut_accumulate dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_rsp  (o_out_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            scoreboard.check_readout(o_out_rsp);
        end
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_in_req random_request();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_in_req)-1:0];
    endfunction

    function automatic t_in_req shaped_request(t_op op, int feat, logic signed [31:0] data);
        t_in_req r;
        r = random_request();
        r.operation     = op;
        r.feature_index = FEAT_W'(feat);
        r.data_value    = data;
        return r;
    endfunction

    function automatic t_in_req accum_request(int feat, logic [7:0] c0, logic [7:0] c1,
                                              logic [7:0] c2, logic [7:0] c3);
        t_in_req r;
        r = shaped_request(OP_ACCUM, feat, $urandom);
        r.code_0 = c0;
        r.code_1 = c1;
        r.code_2 = c2;
        r.code_3 = c3;
        return r;
    endfunction

    function automatic logic [7:0] pick_code(int book);
        if ($urandom_range(0, 99) < 25) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'(live_codes[book][$urandom_range(0, live_codes[book].size() - 1)]);
    endfunction

    function automatic int pick_feature();
        if ($urandom_range(0, 99) < 40) return last_feat;
        return live_feats[$urandom_range(0, live_feats.size() - 1)];
    endfunction

    function automatic logic signed [31:0] lut_data();
        logic [15:0] half;
        half = 16'($urandom);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {{16{half[15]}}, half};
            2: return $urandom_range(0, 512) - 256;
            default: return $urandom_range(0, 1) ? 32767 : -32768;
        endcase
    endfunction

    function automatic logic signed [31:0] preset_data();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'h7fff_0000 | $urandom_range(0, 65535);
            2: return 32'h8000_0000 | $urandom_range(0, 65535);
            default: return $urandom_range(0, 1 << 20) - (1 << 19);
        endcase
    endfunction

    task automatic send_request(input t_in_req req);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < in_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        scoreboard.note_request(req);
        op_count[req.operation]++;
        if (req.operation == OP_TABLE_WR) begin
            if (!lut_live[req.codebook_select][req.entry_index]) begin
                lut_live[req.codebook_select][req.entry_index] = 1'b1;
                live_codes[req.codebook_select].push_back(int'(req.entry_index));
            end
        end else begin
            if (req.operation == OP_PRESET && !feat_live[req.feature_index]) begin
                feat_live[req.feature_index] = 1'b1;
                live_feats.push_back(int'(req.feature_index));
            end
            last_feat = int'(req.feature_index);
        end
    endtask

    task automatic drain_readouts();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.readouts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_books(input logic [CFG_W-1:0] count);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        scoreboard.books = count;
    endtask

    task automatic run_random(input int count, input bit pause_midway);
        t_in_req r;
        int      pick;
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) drain_readouts();
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                r = shaped_request(OP_TABLE_WR, $urandom, lut_data());
            end else if (pick < 30) begin
                r = shaped_request(OP_PRESET,
                                   $urandom_range(0, 1) ? pick_feature()
                                                        : $urandom_range(0, FEATURE_COUNT - 1),
                                   preset_data());
            end else if (pick < 75) begin
                r = accum_request(pick_feature(), pick_code(0), pick_code(1),
                                  pick_code(2), pick_code(3));
            end else begin
                r = shaped_request(OP_READ, pick_feature(), $urandom);
            end
            send_request(r);
        end
    endtask

    initial begin
        t_in_req           r;
        logic signed [31:0] hi_data [4];
        logic signed [31:0] lo_data [4];
        logic [CFG_W-1:0]   seg_books [6];
        hi_data   = '{32'sh7fff_ffff, 32768, 32767, 1};
        lo_data   = '{32'sh8000_0000, -32769, -32768, -1};
        seg_books = '{3'd1, 3'd4, 3'd0, 3'd3, 3'd7, 3'd2};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: both table ends, clamping, clipping up and down, mark cleared by preset
        for (int b = 0; b < BOOK_COUNT; b++) begin
            r = shaped_request(OP_TABLE_WR, $urandom, hi_data[b]);
            r.codebook_select = BOOK_W'(b);
            r.entry_index     = 8'd255;
            send_request(r);
            r = shaped_request(OP_TABLE_WR, $urandom, lo_data[b]);
            r.codebook_select = BOOK_W'(b);
            r.entry_index     = 8'd0;
            send_request(r);
        end
        send_request(shaped_request(OP_PRESET, FEATURE_COUNT - 1, 32'sh7fff_fff0));
        send_request(accum_request(FEATURE_COUNT - 1, 8'd255, 8'd255, 8'd255, 8'd255));
        send_request(shaped_request(OP_READ, FEATURE_COUNT - 1, $urandom));
        send_request(accum_request(FEATURE_COUNT - 1, 8'd0, 8'd0, 8'd0, 8'd0));
        send_request(shaped_request(OP_READ, FEATURE_COUNT - 1, $urandom));
        send_request(shaped_request(OP_PRESET, 0, 32'sh8000_0000));
        send_request(accum_request(0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_request(shaped_request(OP_READ, 0, $urandom));
        send_request(shaped_request(OP_PRESET, 0, 0));
        send_request(shaped_request(OP_READ, 0, $urandom));
        send_request(accum_request(0, 8'd255, 8'd0, 8'd255, 8'd0));
        send_request(shaped_request(OP_READ, 0, $urandom));
        send_request(shaped_request(OP_PRESET, 4095, 12345));
        send_request(shaped_request(OP_READ, 4095, $urandom));
        drain_readouts();

        for (int s = 0; s < 6; s++) begin
            case (s / 2)
                0: begin
                    in_idle_pct   = 16;
                    out_stall_pct = 68;
                end
                1: begin
                    in_idle_pct   = 68;
                    out_stall_pct = 16;
                end
                default: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
            endcase
            write_books(seg_books[s]);
            run_random(SEGMENT_ITEMS, s == 1);
            drain_readouts();
        end

        $display("requests: %0d table writes, %0d presets, %0d accumulates, %0d reads",
                 op_count[OP_TABLE_WR], op_count[OP_PRESET], op_count[OP_ACCUM],
                 op_count[OP_READ]);
        $display("codebook counts 4,1,4,0,3,7,2; %0d readouts checked, %0d with clip mark",
                 scoreboard.readouts_checked, scoreboard.clipped_seen);
        if (scoreboard.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== codebook_lut_accumulate.f =====
+incdir+rtl
rtl/cla_pkg.sv
rtl/cla_table.sv
rtl/codebook_lut_accumulate.sv
test/tb_codebook_lut_accumulate.sv
